// File: rtl/multichannel_debounce_events_unit_defines.svh
// Assertion helpers used by the block's top-level RTL.
`ifndef MULTICHANNEL_DEBOUNCE_EVENTS_UNIT_DEFINES_SVH
`define MULTICHANNEL_DEBOUNCE_EVENTS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MDE_CHECK_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MDE_CHECK_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mde_pkg.sv
package mde_pkg;

  typedef enum logic [1:0] {
    EV_RAW_CHANGE = 2'd0,
    EV_PRESS      = 2'd1,
    EV_RELEASE    = 2'd2
  } ev_kind_t;

  localparam int unsigned RAW_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned DEB_W = 16;
  localparam int unsigned CH_W = 3;
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd30;

  // Events found by one lane for the current scan.
  typedef struct packed {
    logic              raw_v;    // raw-change event pending
    logic              deb_v;    // debounced event pending
    logic              raw;      // raw level after the scan
    logic              deb_old;  // debounced state before this scan's update
    logic              pressed;  // debounced state after the update, valid with deb_v
    logic [TIME_W-1:0] stable;
    logic [TIME_W-1:0] dur;
  } lane_ev_t;

endpackage

// File: rtl/mde_lane.sv
module mde_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          raw_in,
  input  logic [mde_pkg::TIME_W-1:0]    now_ms,
  input  logic [mde_pkg::DEB_W-1:0]     debounce_time,
  input  logic [1:0]                    pop,
  output mde_pkg::lane_ev_t             ev
);

  logic                       raw_r, raw_nxt;
  logic                       deb_r, deb_nxt;
  logic [mde_pkg::TIME_W-1:0] lct_r, lct_nxt;
  logic [mde_pkg::TIME_W-1:0] pst_r, pst_nxt;
  mde_pkg::lane_ev_t          ev_r, ev_nxt;

  logic                       changed;
  logic                       deb_go;
  logic [mde_pkg::TIME_W-1:0] stable;

  always_comb begin
    changed = raw_in != raw_r;
    stable  = changed ? '0 : now_ms - lct_r;
    deb_go  = (stable >= mde_pkg::TIME_W'(debounce_time)) && (deb_r != raw_in);

    raw_nxt = raw_r;
    deb_nxt = deb_r;
    lct_nxt = lct_r;
    pst_nxt = pst_r;
    ev_nxt  = ev_r;

    if (pop[0]) begin
      ev_nxt.raw_v = 1'b0;
    end
    if (pop[1]) begin
      ev_nxt.deb_v = 1'b0;
    end

    if (load) begin
      raw_nxt = raw_in;
      if (changed) begin
        lct_nxt = now_ms;
      end
      if (deb_go) begin
        deb_nxt = raw_in;
        if (raw_in) begin
          pst_nxt = now_ms;
        end
      end
      ev_nxt.raw_v   = changed;
      ev_nxt.deb_v   = deb_go;
      ev_nxt.raw     = raw_in;
      ev_nxt.deb_old = deb_r;
      ev_nxt.pressed = raw_in;
      ev_nxt.stable  = stable;
      ev_nxt.dur     = raw_in ? '0 : now_ms - pst_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r <= 1'b0;
      deb_r <= 1'b0;
      lct_r <= '0;
      pst_r <= '0;
      ev_r  <= '0;
    end else begin
      raw_r <= raw_nxt;
      deb_r <= deb_nxt;
      lct_r <= lct_nxt;
      pst_r <= pst_nxt;
      ev_r  <= ev_nxt;
    end
  end

  assign ev = ev_r;

endmodule

// File: rtl/mde_merge.sv
module mde_merge #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mde_pkg::lane_ev_t             lanes [CHANNELS],
  input  logic [2*CHANNELS-1:0]         pending,
  output logic [2*CHANNELS-1:0]         pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_event_kind,
  output logic [mde_pkg::CH_W-1:0]      out_channel,
  output logic                          out_raw_level,
  output logic                          out_deb_state,
  output logic [mde_pkg::TIME_W-1:0]    out_stable_time,
  output logic [mde_pkg::TIME_W-1:0]    out_press_duration,
  output logic                          out_last_event
);

  localparam int unsigned PW = 2 * CHANNELS;
  localparam int unsigned SW = (PW > 1) ? $clog2(PW) : 1;

  logic [SW-1:0]              sel;
  logic [31:0]                sel_ext;
  logic                       found;
  logic                       take;
  logic                       load;
  logic [PW-1:0]              sel_oh;
  mde_pkg::lane_ev_t          pick;

  logic                       valid_r, valid_nxt;
  mde_pkg::ev_kind_t          kind_r, kind_nxt;
  logic [mde_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic                       raw_r, raw_nxt;
  logic                       deb_r, deb_nxt;
  logic [mde_pkg::TIME_W-1:0] stable_r, stable_nxt;
  logic [mde_pkg::TIME_W-1:0] dur_r, dur_nxt;
  logic                       last_r, last_nxt;

  // Lowest pending event goes first: channel order, raw change before debounce.
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < PW; i++) begin
      if (!found && pending[i]) begin
        sel   = SW'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    sel_ext = 32'(sel);
    pick    = lanes[0];
    for (int i = 0; i < CHANNELS; i++) begin
      if (sel_ext[31:1] == 31'(i)) begin
        pick = lanes[i];
      end
    end
  end

  assign sel_oh = PW'(1) << sel;
  assign take   = !valid_r || !out_stall;
  assign load   = found && take;
  assign pop    = load ? sel_oh : '0;

  always_comb begin
    valid_nxt  = valid_r;
    kind_nxt   = kind_r;
    ch_nxt     = ch_r;
    raw_nxt    = raw_r;
    deb_nxt    = deb_r;
    stable_nxt = stable_r;
    dur_nxt    = dur_r;
    last_nxt   = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      ch_nxt    = sel_ext[mde_pkg::CH_W:1];
      raw_nxt   = pick.raw;
      last_nxt  = (pending & ~sel_oh) == '0;
      if (sel[0]) begin
        kind_nxt   = pick.pressed ? mde_pkg::EV_PRESS : mde_pkg::EV_RELEASE;
        deb_nxt    = pick.pressed;
        stable_nxt = pick.stable;
        dur_nxt    = pick.dur;
      end else begin
        kind_nxt   = mde_pkg::EV_RAW_CHANGE;
        deb_nxt    = pick.deb_old;
        stable_nxt = '0;
        dur_nxt    = '0;
      end
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    ch_r     <= ch_nxt;
    raw_r    <= raw_nxt;
    deb_r    <= deb_nxt;
    stable_r <= stable_nxt;
    dur_r    <= dur_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid          = valid_r;
  assign out_event_kind     = kind_r;
  assign out_channel        = ch_r;
  assign out_raw_level      = raw_r;
  assign out_deb_state      = deb_r;
  assign out_stable_time    = stable_r;
  assign out_press_duration = dur_r;
  assign out_last_event     = last_r;

endmodule

// File: rtl/multichannel_debounce_events_unit.sv
// Multichannel timestamp debouncer with an event stream.
// Input channel (in_valid / in_stall): one scan per transaction, a raw level
// vector plus the scan time in ms. Output channel (out_valid / out_stall):
// one event per transaction, ordered by channel, a raw change ahead of the
// debounced press or release of the same channel; out_last_event marks the
// final event of a scan. A scan with no change produces no transaction.
// Config channel (cfg_valid / cfg_ready): writes debounce_time; always ready,
// write it only while the block is idle.
// One lane per channel evaluates a scan in the cycle it is accepted and
// registers its events; the merge stage moves them into the output register
// one event per cycle while the receiver does not stall. in_stall stays high
// until every event of the scan (up to 2*CHANNELS) has left the lanes; a
// scan with no events does not hold off the next one.
// When the receiver stalls, the output register holds its event and the
// lanes hold the rest. Reset clears all channel state, drops pending
// events and sets debounce_time to 30 ms.
module multichannel_debounce_events_unit #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mde_pkg::RAW_W-1:0]     in_raw_levels,
  input  logic [mde_pkg::TIME_W-1:0]    in_now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_event_kind,
  output logic [mde_pkg::CH_W-1:0]      out_channel,
  output logic                          out_raw_level,
  output logic                          out_deb_state,
  output logic [mde_pkg::TIME_W-1:0]    out_stable_time,
  output logic [mde_pkg::TIME_W-1:0]    out_press_duration,
  output logic                          out_last_event,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mde_pkg::DEB_W-1:0]     cfg_debounce_time
);

`include "multichannel_debounce_events_unit_defines.svh"

  logic [mde_pkg::DEB_W-1:0] deb_time_r, deb_time_nxt;
  logic                      in_take;
  logic                      busy;
  logic [2*CHANNELS-1:0]     pending;
  logic [2*CHANNELS-1:0]     pop;
  mde_pkg::lane_ev_t         lanes [CHANNELS];

  // Config register; the write port never back-pressures.
  assign cfg_ready    = 1'b1;
  assign deb_time_nxt = (cfg_valid && cfg_ready) ? cfg_debounce_time : deb_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_time_r <= mde_pkg::DEBOUNCE_RESET;
    end else begin
      deb_time_r <= deb_time_nxt;
    end
  end

  // Hold off the next scan until every event of this one has left the lanes.
  assign busy     = |pending;
  assign in_stall = busy;
  assign in_take  = in_valid && !in_stall;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic raw_bit;
    if (i < mde_pkg::RAW_W) begin : g_bit
      assign raw_bit = in_raw_levels[i];
    end else begin : g_zero
      // channels beyond the input vector read as inactive
      assign raw_bit = 1'b0;
    end

    mde_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .load          (in_take),
      .raw_in        (raw_bit),
      .now_ms        (in_now_ms),
      .debounce_time (deb_time_r),
      .pop           (pop[2*i+1:2*i]),
      .ev            (lanes[i])
    );

    assign pending[2*i]   = lanes[i].raw_v;
    assign pending[2*i+1] = lanes[i].deb_v;
  end

  // Serialize the lanes' events into the output register.
  mde_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk                (clk),
    .rst_n              (rst_n),
    .lanes              (lanes),
    .pending            (pending),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_kind     (out_event_kind),
    .out_channel        (out_channel),
    .out_raw_level      (out_raw_level),
    .out_deb_state      (out_deb_state),
    .out_stable_time    (out_stable_time),
    .out_press_duration (out_press_duration),
    .out_last_event     (out_last_event)
  );

  // Pending events never wait behind an empty output register.
  `MDE_CHECK_NEXT(a_drain, clk, rst_n, busy && !out_valid, out_valid, "pending event not issued")

  // A new scan enters only once the output register is empty or holds the
  // final event of the previous scan.
  `MDE_CHECK_NOW(a_last_clean, clk, rst_n, in_take, !out_valid || out_last_event, "scan overlaps")

  // A press event reports the channel as pressed, a release as not pressed.
  `MDE_CHECK_NOW(a_press_state, clk, rst_n, out_valid && out_event_kind == mde_pkg::EV_PRESS, out_deb_state, "press not pressed")
  `MDE_CHECK_NOW(a_rel_state, clk, rst_n, out_valid && out_event_kind == mde_pkg::EV_RELEASE, !out_deb_state, "release still pressed")

endmodule
